// ----- hdl/plp_pkg.sv -----
// Shared types, character codes and helpers for the properties line parser.
`default_nettype none

package plp_pkg;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_COMMENT,
    PH_KEY,
    PH_SEP,
    PH_VALUE,
    PH_KEY_HEX,
    PH_VALUE_HEX
  } phase_t;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_FF    = 16'h000C;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_BANG  = 16'h0021;
  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_EQ    = 16'h003D;
  localparam logic [15:0] CH_BSL   = 16'h005C;
  localparam logic [15:0] CH_F     = 16'h0066;
  localparam logic [15:0] CH_N     = 16'h006E;
  localparam logic [15:0] CH_R     = 16'h0072;
  localparam logic [15:0] CH_T     = 16'h0074;
  localparam logic [15:0] CH_U     = 16'h0075;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic logic is_blank(input logic [15:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FF);
  endfunction

  function automatic logic is_eol(input logic [15:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic hex_digit_t hex_digit(input logic [15:0] c);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      d.ok    = 1'b1;
      d.value = c[3:0];
    end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
      d.ok    = 1'b1;
      d.value = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/properties_line_parser.sv -----
// Streaming tokenizer for the properties text format, one code unit per beat.
//
// Input channel (in_valid/in_ready): one beat carries a 16-bit code_unit or,
// with end_of_input high, the end-of-text mark (code_unit is then ignored).
// Output channel (out_valid/out_ready): one beat carries kind and unit_out:
// a decoded key unit, a decoded value unit, an entry end, or a malformed
// \u escape report. An input beat yields zero or one output beat.
//
// Timing: the tokenizer state is a small set of flags updated in the cycle
// an input beat is accepted; a result lands in a two-entry output buffer and
// is offered on the ports the next cycle if nothing is queued ahead. Throughput is
// one input beat per cycle; the buffer depth sets how long the receiver may stall
// before in_ready drops (in_ready is low only while both buffer entries are full).
//
// Reset (rst, synchronous) returns the tokenizer to the start of a line with
// no escape pending and empties the output buffer. An end_of_input beat
// closes any open entry (or reports an unfinished \u) and then puts the
// tokenizer back to the same clean state. After a malformed escape, every
// beat up to and including end_of_input produces nothing.
`default_nettype none

module properties_line_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] code_unit,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      unit_out
);
  import plp_pkg::*;

  // tokenizer state
  phase_t      phase, phase_next;
  logic        escape_pending, escape_pending_next;
  logic [15:0] hex_accumulator, hex_accumulator_next;
  logic [1:0]  hex_digits_seen, hex_digits_seen_next;
  logic        after_continuation, after_continuation_next;
  logic        skip_linefeed, skip_linefeed_next;
  logic        separator_seen, separator_seen_next;
  logic        error_latched, error_latched_next;
  logic        lone_backslash, lone_backslash_next;
  logic        empty_entry_pending, empty_entry_pending_next;

  // result of the current beat
  logic        r_valid;
  logic [1:0]  r_kind;
  logic [15:0] r_unit;

  // scratch for the combinational pass
  logic        go;
  logic        run_key, run_sep, run_value, run_hex;
  logic        text_en;
  logic [1:0]  text_kind;
  logic [15:0] c, esc_unit;
  hex_digit_t  hd;

  // output buffer
  logic [1:0]  count;
  logic [1:0]  slot_kind [2];
  logic [15:0] slot_unit [2];

  logic accept, push, pop;

  assign in_ready  = (count != 2'd2);
  assign accept    = in_valid && in_ready;
  assign push      = accept && r_valid;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign kind      = slot_kind[0];
  assign unit_out  = slot_unit[0];
  assign c         = code_unit;
  assign hd        = hex_digit(code_unit);

  always_comb begin
    phase_next               = phase;
    escape_pending_next      = escape_pending;
    hex_accumulator_next     = hex_accumulator;
    hex_digits_seen_next     = hex_digits_seen;
    after_continuation_next  = after_continuation;
    skip_linefeed_next       = skip_linefeed;
    separator_seen_next      = separator_seen;
    error_latched_next       = error_latched;
    lone_backslash_next      = lone_backslash;
    empty_entry_pending_next = empty_entry_pending;
    r_valid   = 1'b0;
    r_kind    = KIND_KEY;
    r_unit    = 16'd0;
    go        = 1'b0;
    run_key   = 1'b0;
    run_sep   = 1'b0;
    run_value = 1'b0;
    run_hex   = 1'b0;
    text_en   = 1'b0;
    text_kind = KIND_KEY;
    esc_unit  = c;

    if (end_of_input) begin
      if (!error_latched) begin
        if (phase == PH_KEY || phase == PH_SEP || phase == PH_VALUE ||
            (phase == PH_LINE_START && empty_entry_pending)) begin
          r_valid = 1'b1;
          r_kind  = KIND_END;
        end else if (phase == PH_KEY_HEX || phase == PH_VALUE_HEX) begin
          r_valid = 1'b1;
          r_kind  = KIND_BAD;
        end
      end
      phase_next               = PH_LINE_START;
      escape_pending_next      = 1'b0;
      hex_accumulator_next     = 16'd0;
      hex_digits_seen_next     = 2'd0;
      after_continuation_next  = 1'b0;
      skip_linefeed_next       = 1'b0;
      separator_seen_next      = 1'b0;
      error_latched_next       = 1'b0;
      lone_backslash_next      = 1'b0;
      empty_entry_pending_next = 1'b0;
    end else if (!error_latched) begin
      empty_entry_pending_next = 1'b0;
      go = 1'b1;
      // LF right after a CR continuation is part of that line end
      if (skip_linefeed) begin
        skip_linefeed_next = 1'b0;
        if (c == CH_LF) go = 1'b0;
      end
      // leading blanks of a continued line are dropped
      if (go && after_continuation) begin
        if (is_blank(c)) go = 1'b0;
        else after_continuation_next = 1'b0;
      end
      if (go) begin
        case (phase)
          PH_LINE_START: begin
            if (!is_blank(c) && !is_eol(c)) begin
              if (c == CH_HASH || c == CH_BANG) begin
                phase_next = PH_COMMENT;
              end else begin
                phase_next          = PH_KEY;
                separator_seen_next = 1'b0;
                escape_pending_next = 1'b0;
                lone_backslash_next = (c == CH_BSL);
                run_key             = 1'b1;
              end
            end
          end
          PH_COMMENT:   if (is_eol(c)) phase_next = PH_LINE_START;
          PH_KEY:       run_key = 1'b1;
          PH_SEP:       run_sep = 1'b1;
          PH_VALUE:     run_value = 1'b1;
          PH_KEY_HEX,
          PH_VALUE_HEX: run_hex = 1'b1;
          default:      phase_next = PH_LINE_START;
        endcase
      end

      // line ends in key, separator and value phases
      if ((run_key || run_sep || run_value) && is_eol(c)) begin
        if (!escape_pending_next) begin
          phase_next          = PH_LINE_START;
          separator_seen_next = 1'b0;
          r_valid             = 1'b1;
          r_kind              = KIND_END;
        end else if (run_key && lone_backslash_next) begin
          escape_pending_next      = 1'b0;
          lone_backslash_next      = 1'b0;
          phase_next               = PH_LINE_START;
          empty_entry_pending_next = 1'b1;
          skip_linefeed_next       = (c == CH_CR);
        end else begin
          escape_pending_next     = 1'b0;
          after_continuation_next = 1'b1;
          skip_linefeed_next      = (c == CH_CR);
        end
      end else if (run_key) begin
        if (c != CH_BSL || escape_pending_next) lone_backslash_next = 1'b0;
        if (!escape_pending_next && (c == CH_EQ || c == CH_COLON)) begin
          phase_next          = PH_SEP;
          separator_seen_next = 1'b1;
        end else if (!escape_pending_next && is_blank(c)) begin
          phase_next          = PH_SEP;
          separator_seen_next = 1'b0;
        end else begin
          text_en   = 1'b1;
          text_kind = KIND_KEY;
        end
      end else if (run_sep) begin
        if (escape_pending) begin
          phase_next = PH_VALUE;
          text_en    = 1'b1;
          text_kind  = KIND_VALUE;
        end else if (c == CH_BSL) begin
          escape_pending_next = 1'b1;
        end else if (is_blank(c)) begin
          // separator blanks skipped
        end else if ((c == CH_EQ || c == CH_COLON) && !separator_seen) begin
          separator_seen_next = 1'b1;
        end else begin
          phase_next = PH_VALUE;
          text_en    = 1'b1;
          text_kind  = KIND_VALUE;
        end
      end else if (run_value) begin
        text_en   = 1'b1;
        text_kind = KIND_VALUE;
      end

      // \u digits
      if (run_hex) begin
        if (is_eol(c)) begin
          if (!escape_pending) begin
            error_latched_next = 1'b1;
            r_valid            = 1'b1;
            r_kind             = KIND_BAD;
          end else begin
            escape_pending_next     = 1'b0;
            after_continuation_next = 1'b1;
            skip_linefeed_next      = (c == CH_CR);
          end
        end else if (escape_pending || (c != CH_BSL && !hd.ok)) begin
          error_latched_next = 1'b1;
          r_valid            = 1'b1;
          r_kind             = KIND_BAD;
        end else if (c == CH_BSL) begin
          escape_pending_next = 1'b1;
        end else begin
          hex_accumulator_next = {hex_accumulator[11:0], hd.value};
          hex_digits_seen_next = hex_digits_seen + 2'd1;
          if (hex_digits_seen == 2'd3) begin
            phase_next = (phase == PH_KEY_HEX) ? PH_KEY : PH_VALUE;
            r_valid    = 1'b1;
            r_kind     = (phase == PH_KEY_HEX) ? KIND_KEY : KIND_VALUE;
            r_unit     = {hex_accumulator[11:0], hd.value};
          end
        end
      end

      // plain or escaped text unit
      if (text_en) begin
        if (escape_pending_next) begin
          escape_pending_next = 1'b0;
          if (c == CH_U) begin
            phase_next           = (text_kind == KIND_KEY) ? PH_KEY_HEX : PH_VALUE_HEX;
            hex_accumulator_next = 16'd0;
            hex_digits_seen_next = 2'd0;
          end else begin
            case (c)
              CH_T:    esc_unit = CH_TAB;
              CH_R:    esc_unit = CH_CR;
              CH_N:    esc_unit = CH_LF;
              CH_F:    esc_unit = CH_FF;
              default: esc_unit = c;
            endcase
            r_valid = 1'b1;
            r_kind  = text_kind;
            r_unit  = esc_unit;
          end
        end else if (c == CH_BSL) begin
          escape_pending_next = 1'b1;
        end else begin
          r_valid = 1'b1;
          r_kind  = text_kind;
          r_unit  = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_LINE_START;
      escape_pending      <= 1'b0;
      hex_accumulator     <= 16'd0;
      hex_digits_seen     <= 2'd0;
      after_continuation  <= 1'b0;
      skip_linefeed       <= 1'b0;
      separator_seen      <= 1'b0;
      error_latched       <= 1'b0;
      lone_backslash      <= 1'b0;
      empty_entry_pending <= 1'b0;
    end else if (accept) begin
      phase               <= phase_next;
      escape_pending      <= escape_pending_next;
      hex_accumulator     <= hex_accumulator_next;
      hex_digits_seen     <= hex_digits_seen_next;
      after_continuation  <= after_continuation_next;
      skip_linefeed       <= skip_linefeed_next;
      separator_seen      <= separator_seen_next;
      error_latched       <= error_latched_next;
      lone_backslash      <= lone_backslash_next;
      empty_entry_pending <= empty_entry_pending_next;
    end
  end

  // Two-entry output buffer; slot 0 is the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // head takes the new beat when the buffer is, or is about to be, empty
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      slot_kind[0] <= r_kind;
      slot_unit[0] <= r_unit;
    end else if (pop) begin
      slot_kind[0] <= slot_kind[1];
      slot_unit[0] <= slot_unit[1];
    end
    if (push && count == 2'd1 && !pop) begin
      slot_kind[1] <= r_kind;
      slot_unit[1] <= r_unit;
    end
  end

  // buffer never overfills
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer count out of range");

  // once a bad escape is reported, nothing more until end of input
  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    accept && error_latched && !end_of_input |-> !r_valid)
    else $error("result produced after malformed escape");

  // entry end and error carry a zero unit
  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    push && (r_kind == KIND_END || r_kind == KIND_BAD) |-> r_unit == 16'd0)
    else $error("nonzero unit on marker result");

  // end of input leaves a clean tokenizer
  a_eoi_clean: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> phase == PH_LINE_START && !escape_pending && !error_latched)
    else $error("state not cleared after end of input");

  // digit counter idles at zero outside \u decoding
  a_hex_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_KEY_HEX && phase != PH_VALUE_HEX |-> hex_digits_seen == 2'd0)
    else $error("hex digit count live outside escape");

endmodule

`default_nettype wire
